>>> src/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> src/salru_pkg.sv
// Shared types of the LRU tag store: request/response payloads and the
// controller/datapath command and status groups. No dependencies.
package salru_pkg;

	typedef struct packed {
		logic        action;
		logic [31:0] address;
		logic        fill_dirty;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic        evict_valid;
		logic        evict_dirty;
		logic [31:0] evict_address;
	} rsp_t;

	localparam logic ACT_ACCESS     = 1'b0;
	localparam logic ACT_INVALIDATE = 1'b1;

	typedef struct packed {
		logic capture;
		logic clear_step;
		logic commit;
		logic pop;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_full;
	} sts_t;

endpackage

>>> src/salru_ctrl.sv
// Sequencer of the LRU tag store: clearing pass, request capture, commit.
// Depends on salru_pkg (cmd_t, sts_t).
module salru_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic              rsp_ready,
	input  salru_pkg::sts_t   sts,
	output salru_pkg::cmd_t   cmd
);

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_LOOKUP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d        = state_q;
		req_ready      = 1'b0;
		cmd.capture    = 1'b0;
		cmd.clear_step = 1'b0;
		cmd.commit     = 1'b0;
		cmd.pop        = sts.out_full & rsp_ready;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
				if (req_valid)
					state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				// result register must be free (or draining) before write-back
				cmd.commit = ~sts.out_full | rsp_ready;
				if (cmd.commit)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

endmodule

>>> src/salru_dp.sv
// Datapath of the LRU tag store: per-set row memories, tag compare,
// recency update, fill/invalidate and the result register. Uses salru_pkg.
module salru_dp #(
	parameter int SETS        = 64,
	parameter int WAYS        = 4,
	parameter int BLOCK_BYTES = 32,
	parameter int ADDR_BITS   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  salru_pkg::req_t   req,
	input  salru_pkg::cmd_t   cmd,
	output salru_pkg::rsp_t   rsp,
	output salru_pkg::sts_t   sts
);

	localparam int OFF_BITS = $clog2(BLOCK_BYTES + 1) - 1;
	localparam int IDX_BITS = $clog2(SETS + 1) - 1;
	localparam int LOW_BITS = OFF_BITS + IDX_BITS;
	localparam int EFF_BITS = (ADDR_BITS < 32) ? ADDR_BITS : 32;
	localparam bit HAS_TAG  = EFF_BITS > LOW_BITS;
	localparam int TAG_W    = HAS_TAG ? (EFF_BITS - LOW_BITS) : 1;
	localparam int ROW_W    = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam logic [31:0] AMASK =
		(ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);
	localparam logic [ROW_W-1:0] IDX_MASK = ROW_W'((64'd1 << IDX_BITS) - 64'd1);
	localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(WAYS - 1);
	localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SETS - 1);

	// row memories, one row per set
	logic [WAYS-1:0][TAG_W-1:0]  mem_tag   [SETS];
	logic [WAYS-1:0][31:0]       mem_addr  [SETS];
	logic [WAYS-1:0]             mem_valid [SETS];
	logic [WAYS-1:0]             mem_dirty [SETS];
	logic [WAYS-1:0][RANK_W-1:0] mem_rank  [SETS];

	logic [WAYS-1:0][TAG_W-1:0]  rd_tag_q;
	logic [WAYS-1:0][31:0]       rd_addr_q;
	logic [WAYS-1:0]             rd_valid_q;
	logic [WAYS-1:0]             rd_dirty_q;
	logic [WAYS-1:0][RANK_W-1:0] rd_rank_q;

	logic [WAYS-1:0][TAG_W-1:0]  wr_tag;
	logic [WAYS-1:0][31:0]       wr_addr;
	logic [WAYS-1:0]             wr_valid;
	logic [WAYS-1:0]             wr_dirty;
	logic [WAYS-1:0][RANK_W-1:0] wr_rank;
	logic                        wr_en;
	logic [ROW_W-1:0]            wr_row;

	logic [WAYS-1:0][TAG_W-1:0]  new_tag;
	logic [WAYS-1:0][31:0]       new_addr;
	logic [WAYS-1:0]             new_valid;
	logic [WAYS-1:0]             new_dirty;
	logic [WAYS-1:0][RANK_W-1:0] new_rank;

	salru_pkg::req_t  req_q;
	logic [TAG_W-1:0] tag_q;
	logic [ROW_W-1:0] set_q;
	logic [ROW_W-1:0] clr_q;
	logic             out_full_q;
	salru_pkg::rsp_t  rsp_q;

	logic [31:0]       req_am;
	logic [31:0]       req_sh;
	logic [ROW_W-1:0]  req_set;
	logic [TAG_W-1:0]  req_tag;

	logic              hit_c;
	logic [RANK_W-1:0] hit_way;
	logic [RANK_W-1:0] vic_way;
	logic [RANK_W-1:0] sel_way;
	logic [RANK_W-1:0] sel_rank;
	logic              do_mru;
	logic              do_lru;
	logic              do_fill;
	logic              evict_c;
	salru_pkg::rsp_t   rsp_c;

	// address split
	assign req_am  = req.address & AMASK;
	assign req_sh  = req_am >> OFF_BITS;
	assign req_set = req_sh[ROW_W-1:0] & IDX_MASK;
	assign req_tag = HAS_TAG ? TAG_W'(req_am >> LOW_BITS) : '0;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
			tag_q <= req_tag;
			set_q <= req_set;
		end
	end

	// lookup, victim choice and recency update on the registered row
	always_comb begin
		hit_c   = 1'b0;
		hit_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!hit_c && rd_valid_q[w] && rd_tag_q[w] == tag_q) begin
				hit_c   = 1'b1;
				hit_way = RANK_W'(w);
			end
		end
		vic_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (rd_rank_q[w] == LAST_RANK)
				vic_way = RANK_W'(w);
		end
		sel_way  = hit_c ? hit_way : vic_way;
		sel_rank = rd_rank_q[sel_way];
		do_mru   = req_q.action == salru_pkg::ACT_ACCESS;
		do_lru   = (req_q.action == salru_pkg::ACT_INVALIDATE) && hit_c;
		do_fill  = do_mru && !hit_c;

		new_tag   = rd_tag_q;
		new_addr  = rd_addr_q;
		new_valid = rd_valid_q;
		new_dirty = rd_dirty_q;
		new_rank  = rd_rank_q;
		for (int k = 0; k < WAYS; k++) begin
			if (do_mru) begin
				if (RANK_W'(k) == sel_way)
					new_rank[k] = '0;
				else if (rd_rank_q[k] < sel_rank)
					new_rank[k] = rd_rank_q[k] + RANK_W'(1);
			end else if (do_lru) begin
				if (RANK_W'(k) == sel_way)
					new_rank[k] = LAST_RANK;
				else if (rd_rank_q[k] > sel_rank)
					new_rank[k] = rd_rank_q[k] - RANK_W'(1);
			end
		end
		if (do_fill) begin
			new_tag[vic_way]   = tag_q;
			new_addr[vic_way]  = req_q.address;
			new_valid[vic_way] = 1'b1;
			new_dirty[vic_way] = req_q.fill_dirty;
		end
		if (do_lru) begin
			new_tag[hit_way]   = '0;
			new_addr[hit_way]  = '0;
			new_valid[hit_way] = 1'b0;
			new_dirty[hit_way] = 1'b0;
		end

		evict_c             = do_fill && rd_valid_q[vic_way];
		rsp_c.hit           = hit_c;
		rsp_c.evict_valid   = evict_c;
		rsp_c.evict_dirty   = evict_c & rd_dirty_q[vic_way];
		rsp_c.evict_address = evict_c ? rd_addr_q[vic_way] : 32'd0;
	end

	// write port: clearing pass after reset, else write-back of the looked-up row
	always_comb begin
		wr_en  = cmd.clear_step | cmd.commit;
		wr_row = cmd.clear_step ? clr_q : set_q;
		if (cmd.clear_step) begin
			wr_tag   = '0;
			wr_addr  = '0;
			wr_valid = '0;
			wr_dirty = '0;
			for (int w = 0; w < WAYS; w++)
				wr_rank[w] = RANK_W'(w);
		end else begin
			wr_tag   = new_tag;
			wr_addr  = new_addr;
			wr_valid = new_valid;
			wr_dirty = new_dirty;
			wr_rank  = new_rank;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_tag[wr_row]   <= wr_tag;
			mem_addr[wr_row]  <= wr_addr;
			mem_valid[wr_row] <= wr_valid;
			mem_dirty[wr_row] <= wr_dirty;
			mem_rank[wr_row]  <= wr_rank;
		end
		if (cmd.capture) begin
			rd_tag_q   <= mem_tag[req_set];
			rd_addr_q  <= mem_addr[req_set];
			rd_valid_q <= mem_valid[req_set];
			rd_dirty_q <= mem_dirty[req_set];
			rd_rank_q  <= mem_rank[req_set];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (cmd.clear_step && clr_q != LAST_ROW)
				clr_q <= clr_q + ROW_W'(1);
			if (cmd.commit)
				out_full_q <= 1'b1;
			else if (cmd.pop)
				out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit)
			rsp_q <= rsp_c;
	end

	assign rsp            = rsp_q;
	assign sts.out_full   = out_full_q;
	assign sts.clear_last = clr_q == LAST_ROW;

endmodule

>>> src/set_assoc_lru_tag_store.sv
// Set-associative tag store with true LRU order per set.
// A request is captured with its set's row, then committed: the result goes
// to the response register (rsp_valid) and the row is written back. Requests
// are taken one at a time; a full response register not being drained stalls commit.
// Reset: async active low; then a clearing pass over every row with req_ready low.
module set_assoc_lru_tag_store #(
	parameter int SETS        = 64,
	parameter int WAYS        = 4,
	parameter int BLOCK_BYTES = 32,
	parameter int ADDR_BITS   = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  salru_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output salru_pkg::rsp_t rsp
);

	salru_pkg::cmd_t cmd;
	salru_pkg::sts_t sts;

	salru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	salru_dp #(
		.SETS        (SETS),
		.WAYS        (WAYS),
		.BLOCK_BYTES (BLOCK_BYTES),
		.ADDR_BITS   (ADDR_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.rsp    (rsp),
		.sts    (sts)
	);

	assign rsp_valid = sts.out_full;

endmodule

>>> src/salru_chk.sv
// Port-level checker for the LRU tag store, bound to the top level.
// Depends on salru_pkg and assert_macros.svh.
`include "assert_macros.svh"

module salru_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input salru_pkg::rsp_t rsp
);

	logic req_fire;
	assign req_fire = req_valid & req_ready;

	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_fire, !req_ready)
	`ASSERT_IMPL(a_hit_no_evict, clk, arst_n, rsp_valid && rsp.hit, !rsp.evict_valid && !rsp.evict_dirty)
	`ASSERT_IMPL(a_no_evict_zero, clk, arst_n, rsp_valid && !rsp.evict_valid, !rsp.evict_dirty && rsp.evict_address == 32'd0)
	`ASSERT_IMPL(a_rsp_from_req, clk, arst_n, $rose(rsp_valid), $past(req_fire, 2))

endmodule

bind set_assoc_lru_tag_store salru_chk u_salru_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
